[rtl/nrzpw_pkg.sv]
`default_nettype none

package nrzpw_pkg;

    // Frame size and the buffer that holds it
    localparam int MAX_BITS   = 128;
    localparam int BUF_BYTES  = (MAX_BITS + 7) / 8;
    localparam int BUF_IDX_W  = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
    localparam int BIT_POS_W  = ($clog2(MAX_BITS) > 3) ? $clog2(MAX_BITS) : 4;
    localparam int BITS_W     = $clog2(MAX_BITS + 1);

    // Field widths
    localparam int TICK_W     = 16;
    localparam int CNT_W      = 21;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    // Action codes
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT  = 3'd4;

    // Reset values of the configuration registers
    localparam logic [TICK_W-1:0]  RST_ONE_HIGH   = 16'd200;
    localparam logic [TICK_W-1:0]  RST_ZERO_HIGH  = 16'd100;
    localparam logic [TICK_W-1:0]  RST_BIT_PERIOD = 16'd300;
    localparam logic [CNT_W-1:0]   RST_PAUSE      = 21'd1200000;
    localparam logic [COUNT_W-1:0] RST_BIT_COUNT  = 8'd120;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] byte_index;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic done_res;
    } out_result_t;

    typedef struct packed {
        logic [TICK_W-1:0]  one_high_ticks;
        logic [TICK_W-1:0]  zero_high_ticks;
        logic [TICK_W-1:0]  bit_period_ticks;
        logic [CNT_W-1:0]   pause_ticks;
        logic [COUNT_W-1:0] bit_count;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/nrz_led_pulse_width_encoder_top.sv]
`default_nettype none
// A result passes through the input register, then the result register, before it is
// valid. Throughput: one transaction per cycle unless out_ready stalls the result;
// the frame state updates in a single pass.
// Reset: rst_n clears the frame state and handshake flags and loads the default
// timing registers; the message buffer is not cleared and must be loaded before use.

module nrz_led_pulse_width_encoder_top
    import nrzpw_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_item_t              in_item,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_result_t                out_result,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic        in_valid_reg;
    in_item_t    in_data_reg;
    logic        out_valid_reg;
    out_result_t out_data_reg;
    cfg_t        cfg_reg;
    out_result_t result;
    logic        advance;

    // Move a transaction on when the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_result = out_data_reg;
    assign cfg_ready = 1'b1;

    nrzpw_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_data_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_data_reg <= in_item;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= result;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.one_high_ticks   <= RST_ONE_HIGH;
            cfg_reg.zero_high_ticks  <= RST_ZERO_HIGH;
            cfg_reg.bit_period_ticks <= RST_BIT_PERIOD;
            cfg_reg.pause_ticks      <= RST_PAUSE;
            cfg_reg.bit_count        <= RST_BIT_COUNT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ONE_HIGH:   cfg_reg.one_high_ticks   <= cfg_data[TICK_W-1:0];
                CFG_ZERO_HIGH:  cfg_reg.zero_high_ticks  <= cfg_data[TICK_W-1:0];
                CFG_BIT_PERIOD: cfg_reg.bit_period_ticks <= cfg_data[TICK_W-1:0];
                CFG_PAUSE:      cfg_reg.pause_ticks      <= cfg_data[CNT_W-1:0];
                CFG_BIT_COUNT:  cfg_reg.bit_count        <= cfg_data[COUNT_W-1:0];
                default:        cfg_reg                  <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/nrzpw_engine.sv]
`default_nettype none

module nrzpw_engine
    import nrzpw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire in_item_t    item,
    input  wire cfg_t        cfg,
    output out_result_t      result
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SEND  = 2'd1,
        PH_PAUSE = 2'd2
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [BIT_POS_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [7:0]             buffer_reg [BUF_BYTES];

    logic [TICK_W-1:0]      eff_period;
    logic [CNT_W-1:0]       eff_pause;
    logic [BITS_W-1:0]      eff_bits;
    logic [BUF_IDX_W-1:0]   byte_i;
    logic [7:0]             cur_byte;
    logic                   cur_bit;
    logic [TICK_W-1:0]      cur_high;
    logic [TICK_W-1:0]      start_high;
    logic                   level_cur;
    logic                   level_start;
    logic [CNT_W-1:0]       cnt_inc;
    logic [BIT_POS_W:0]     pos_inc;
    logic                   load_en;
    logic                   level;
    logic                   done;

    // Clamp the timing registers to their usable range
    always_comb
    begin
        eff_period = (cfg.bit_period_ticks < TICK_W'(2)) ? TICK_W'(2) : cfg.bit_period_ticks;
        eff_pause  = (cfg.pause_ticks == '0) ? CNT_W'(1) : cfg.pause_ticks;
        if (cfg.bit_count == '0)
            eff_bits = BITS_W'(1);
        else if (32'(cfg.bit_count) > MAX_BITS)
            eff_bits = BITS_W'(MAX_BITS);
        else
            eff_bits = BITS_W'(cfg.bit_count);
    end

    // Pick the current bit, MSB first, and its high time
    always_comb
    begin
        byte_i      = BUF_IDX_W'(pos_reg[BIT_POS_W-1:3]);
        cur_byte    = buffer_reg[byte_i];
        cur_bit     = cur_byte[~pos_reg[2:0]];
        cur_high    = cur_bit ? cfg.one_high_ticks : cfg.zero_high_ticks;
        level_cur   = (phase_reg == PH_SEND) && (cnt_reg < CNT_W'(cur_high));
        start_high  = buffer_reg[0][7] ? cfg.one_high_ticks : cfg.zero_high_ticks;
        level_start = (start_high != '0);
        cnt_inc     = cnt_reg + CNT_W'(1);
        pos_inc     = {1'b0, pos_reg} + (BIT_POS_W+1)'(1);
    end

    // Advance the frame state for one transaction
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        load_en    = 1'b0;
        level      = 1'b0;
        done       = 1'b0;
        if (item.action == ACT_TICK)
        begin
            level = level_cur;
            case (phase_reg)
                PH_SEND:
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= CNT_W'(eff_period))
                    begin
                        cnt_next = '0;
                        pos_next = pos_inc[BIT_POS_W-1:0];
                        if (32'(pos_inc) >= 32'(eff_bits))
                        begin
                            pos_next   = '0;
                            phase_next = PH_PAUSE;
                        end
                    end
                end
                PH_PAUSE:
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= eff_pause)
                    begin
                        cnt_next   = '0;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        else if (phase_reg == PH_IDLE)
        begin
            if (item.action == ACT_LOAD)
            begin
                load_en = (32'(item.byte_index) < BUF_BYTES);
            end
            else if (item.action == ACT_START)
            begin
                phase_next = PH_SEND;
                pos_next   = '0;
                cnt_next   = '0;
                level      = level_start;
            end
        end
        else
        begin
            level = level_cur;
        end
        result.line_level = level;
        result.busy_res   = (phase_next != PH_IDLE);
        result.done_res   = done;
    end

    // Hold frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Write message bytes
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < BUF_BYTES; i++)
        begin
            if (fire && load_en && (32'(item.byte_index) == i))
                buffer_reg[i] <= item.byte_value;
        end
    end

endmodule

`default_nettype wire

[tb/sv/tb_nrz_led_pulse_width_encoder_top.sv]
`timescale 1ns / 100ps

module tb_nrz_led_pulse_width_encoder_top;
    import nrzpw_pkg::*;

    localparam int WORK_ITEMS      = 1600;
    localparam int HOLD_OFF_AT     = 400;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 16;
    localparam int REPORT_LIMIT    = 200;

    localparam logic [TICK_W-1:0]  TICKS_MAX = '1;
    localparam logic [CNT_W-1:0]   PAUSE_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Action code the block has no use for
    localparam logic [1:0] ACT_SPARE = 2'd3;

    // Buffer contents for the opening fill; the first byte carries a one then a zero
    localparam logic [7:0] FILL_BYTES [16] = '{
        8'hA5, 8'hFF, 8'h00, 8'h5A, 8'h80, 8'h01, 8'h7F, 8'hFE,
        8'hC3, 8'h3C, 8'h96, 8'h69, 8'hF0, 8'h0F, 8'h55, 8'hAA
    };

    typedef enum logic [1:0] {PH_IDLE, PH_SEND, PH_PAUSE} frame_phase_t;

    // Line state predictor plus the queue of expected results
    class led_line_scoreboard;
        logic [TICK_W-1:0]  one_high;
        logic [TICK_W-1:0]  zero_high;
        logic [TICK_W-1:0]  period;
        logic [CNT_W-1:0]   pause_len;
        logic [COUNT_W-1:0] nbits;
        logic [7:0]         msg [BUF_BYTES];
        logic [7:0]         bit_pos;
        logic [CNT_W-1:0]   tick_cnt;
        frame_phase_t       phase;
        out_result_t        expected_q [$];
        int                 errors;
        int                 checked;

        function new();
            one_high  = RST_ONE_HIGH;
            zero_high = RST_ZERO_HIGH;
            period    = RST_BIT_PERIOD;
            pause_len = RST_PAUSE;
            nbits     = RST_BIT_COUNT;
            foreach (msg[i])
                msg[i] = '0;
            bit_pos  = '0;
            tick_cnt = '0;
            phase    = PH_IDLE;
            errors   = 0;
            checked  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ONE_HIGH:   one_high  = data[TICK_W-1:0];
                CFG_ZERO_HIGH:  zero_high = data[TICK_W-1:0];
                CFG_BIT_PERIOD: period    = data[TICK_W-1:0];
                CFG_PAUSE:      pause_len = data[CNT_W-1:0];
                CFG_BIT_COUNT:  nbits     = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Saturate the bit count to the buffer size; a zero count gives one bit
        function int unsigned frame_bits();
            if (nbits == 0)
                return 1;
            if (nbits > MAX_BITS)
                return MAX_BITS;
            return nbits;
        endfunction

        function int unsigned slot_ticks();
            return (period < 2) ? 2 : period;
        endfunction

        function int unsigned pause_span();
            return (pause_len == 0) ? 1 : pause_len;
        endfunction

        // Level of the line for the current slot position, MSB of each byte first
        function logic line_now();
            logic [7:0] cur_byte;
            logic       bit_val;
            if (phase != PH_SEND)
                return 1'b0;
            cur_byte = msg[bit_pos >> 3];
            bit_val  = cur_byte[3'd7 - bit_pos[2:0]];
            return tick_cnt < (bit_val ? one_high : zero_high);
        endfunction

        function bit busy();
            return phase != PH_IDLE;
        endfunction

        // Advance the frame state for one accepted transaction and queue its result
        function void note_item(in_item_t it);
            out_result_t r;
            r = '0;
            if (it.action == ACT_TICK) begin
                r.line_level = line_now();
                if (phase == PH_SEND) begin
                    tick_cnt = tick_cnt + 1'b1;
                    if (tick_cnt >= slot_ticks()) begin
                        tick_cnt = '0;
                        bit_pos  = bit_pos + 1'b1;
                        if (bit_pos >= frame_bits()) begin
                            bit_pos = '0;
                            phase   = PH_PAUSE;
                        end
                    end
                end
                else if (phase == PH_PAUSE) begin
                    tick_cnt = tick_cnt + 1'b1;
                    if (tick_cnt >= pause_span()) begin
                        tick_cnt   = '0;
                        phase      = PH_IDLE;
                        r.done_res = 1'b1;
                    end
                end
            end
            else begin
                // Loads and starts count only while idle
                if (phase == PH_IDLE) begin
                    if (it.action == ACT_LOAD)
                        msg[it.byte_index] = it.byte_value;
                    else if (it.action == ACT_START) begin
                        phase    = PH_SEND;
                        bit_pos  = '0;
                        tick_cnt = '0;
                    end
                end
                r.line_level = line_now();
            end
            r.busy_res = (phase != PH_IDLE);
            expected_q.push_back(r);
        endfunction

        function void compare_bit(string name, logic want, logic got);
            if (got !== want) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: %s mismatch, expected %b actual %b", $time, name, want, got);
            end
        endfunction

        function void check_result(out_result_t got);
            out_result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: result %b arrived with none expected", $time, got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_bit("line_level", want.line_level, got.line_level);
            compare_bit("busy_res", want.busy_res, got.busy_res);
            compare_bit("done_res", want.done_res, got.done_res);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_ready;
    out_result_t           out_result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    led_line_scoreboard sb = new();
    int burst_left;
    int work_items;

    nrz_led_pulse_width_encoder_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one transaction; open a new burst after a random gap when the last one ran out
    task automatic send_item(input in_item_t it);
        @(negedge clk);
        if (burst_left == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        in_item  = it;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_item(it);
        burst_left--;
    endtask

    task automatic send_action(input logic [1:0] act);
        in_item_t it;
        it.action     = act;
        it.byte_index = 4'($urandom_range(0, 15));
        it.byte_value = 8'($urandom_range(0, 255));
        send_item(it);
    endtask

    task automatic send_load(input logic [3:0] idx, input logic [7:0] val);
        in_item_t it;
        it.action     = ACT_LOAD;
        it.byte_index = idx;
        it.byte_value = val;
        send_item(it);
    endtask

    // Drop valid and hold until every queued result has come back
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Rewrite all timing registers once the block is idle; unused upper bits carry junk
    task automatic set_timing(input logic [TICK_W-1:0] one, input logic [TICK_W-1:0] zero,
                              input logic [TICK_W-1:0] per, input logic [CNT_W-1:0] pau,
                              input logic [COUNT_W-1:0] nb);
        logic [CFG_DATA_W-1:0] junk;
        wait_drained();
        junk = CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
        write_cfg(CFG_ONE_HIGH, {junk[CFG_DATA_W-1:TICK_W], one});
        write_cfg(CFG_ZERO_HIGH, {~junk[CFG_DATA_W-1:TICK_W], zero});
        write_cfg(CFG_BIT_PERIOD, {junk[CFG_DATA_W-1:TICK_W], per});
        write_cfg(CFG_PAUSE, pau);
        write_cfg(CFG_BIT_COUNT, {junk[CFG_DATA_W-1:COUNT_W], nb});
    endtask

    task automatic random_timing();
        logic [TICK_W-1:0]  one;
        logic [TICK_W-1:0]  zero;
        logic [TICK_W-1:0]  per;
        logic [CNT_W-1:0]   pau;
        logic [COUNT_W-1:0] nb;
        one  = TICK_W'($urandom_range(0, 8));
        zero = TICK_W'($urandom_range(0, 8));
        per  = TICK_W'($urandom_range(0, 8));
        pau  = CNT_W'($urandom_range(0, 6));
        nb   = COUNT_W'($urandom_range(1, 12));
        case ($urandom_range(0, 7))
            0: begin
                // short slots with empty, full and over-range bit counts
                per = TICK_W'($urandom_range(0, 3));
                case ($urandom_range(0, 3))
                    0:       nb = '0;
                    1:       nb = COUNT_W'(MAX_BITS);
                    2:       nb = COUNT_W'(MAX_BITS + 1);
                    default: nb = COUNT_MAX;
                endcase
            end
            1: begin
                // high times at or past the slot length
                one  = TICKS_MAX;
                zero = per + TICK_W'($urandom_range(0, 2));
            end
            default: ;
        endcase
        set_timing(one, zero, per, pau, nb);
    endtask

    // Load a few bytes, start a frame, then tick it through to the done pulse
    task automatic run_frame();
        int n_loads;
        int pick;
        n_loads = $urandom_range(0, 4);
        repeat (n_loads) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                send_action(ACT_TICK);
            else if (pick == 1)
                send_action(ACT_SPARE);
            else begin
                send_load(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
                work_items++;
            end
        end
        send_action(ACT_START);
        work_items++;
        while (sb.busy()) begin
            pick = $urandom_range(0, 19);
            case (pick)
                0:       send_action(ACT_LOAD);
                1:       send_action(ACT_START);
                2:       send_action(ACT_SPARE);
                default:
                begin
                    send_action(ACT_TICK);
                    work_items++;
                end
            endcase
        end
    endtask

    // Main sequence
    initial
    begin
        in_valid   = 1'b0;
        in_item    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        rst_n      = 1'b0;
        burst_left = 0;
        work_items = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Fill every buffer entry so no frame ever reads an unwritten byte
        for (int i = 0; i < BUF_BYTES; i++)
            send_load(4'(i), FILL_BYTES[i]);
        send_action(ACT_TICK);
        send_action(ACT_SPARE);

        // Unused register indexes, then a two-bit frame on the reset slot timing
        wait_drained();
        write_cfg(CFG_PAUSE, CFG_DATA_W'(1));
        write_cfg(CFG_BIT_COUNT, CFG_DATA_W'(2));
        for (int k = CFG_BIT_COUNT + 1; k < (1 << CFG_IDX_W); k++)
            write_cfg(CFG_IDX_W'(k), CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
        send_action(ACT_START);
        send_load(4'd0, 8'h00);
        send_action(ACT_START);
        send_action(ACT_SPARE);
        while (sb.busy())
            send_action(ACT_TICK);

        // Random frames over changing timing
        random_timing();
        while (work_items < WORK_ITEMS) begin
            if ($urandom_range(0, 2) == 0)
                random_timing();
            run_frame();
        end

        // Whole slot high for a one bit, whole slot low for a zero bit
        set_timing(TICKS_MAX, '0, TICK_W'(24), CNT_W'(1), COUNT_W'(2));
        send_action(ACT_START);
        while (sb.busy())
            send_action(ACT_TICK);

        // Longest pause, entered but not finished
        set_timing(TICK_W'(1), TICK_W'(1), TICK_W'(2), PAUSE_MAX, COUNT_W'(2));
        send_action(ACT_START);
        repeat (304) send_action(ACT_TICK);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb_nrz_led_pulse_width_encoder_top: PASS");
        else
            $display("tb_nrz_led_pulse_width_encoder_top: FAIL");
        $finish;
    end

    // Result side: stall in random windows, with one long hold-off
    initial
    begin
        int  mode;
        int  window;
        bit  held;
        out_ready = 1'b0;
        mode      = 0;
        window    = 0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (!held && sb.checked >= HOLD_OFF_AT) begin
                held      = 1'b1;
                out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            if (window == 0) begin
                mode   = $urandom_range(0, 3);
                window = $urandom_range(8, 64);
            end
            window--;
            case (mode)
                0:       out_ready = 1'b1;
                1:       out_ready = ($urandom_range(0, 1) == 1);
                2:       out_ready = ~out_ready;
                default: out_ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Check each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_result);
    end

    initial
    begin
        #40_000_000;
        $display("tb_nrz_led_pulse_width_encoder_top: FAIL");
        $finish;
    end

endmodule
